### rtl/mgp_pkg.sv
// Shared widths, codes and control/status types for the genotype probability block.
`default_nettype none
package mgp_pkg;

    localparam int IND_W  = 10;
    localparam int GENO_W = 2;
    localparam int POS_W  = 2;
    localparam int R_W    = 16;
    localparam int Q_W    = 17;
    localparam int PROB_W = 48;
    localparam int FAC_W  = 33;
    localparam int MUL_AW = 48;
    localparam int MUL_BW = 17;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << 46;
    localparam logic [Q_W-1:0]    Q_ONE    = Q_W'(1) << R_W;

    localparam logic [GENO_W-1:0] GENO_HET     = 2'd1;
    localparam logic [POS_W-1:0]  POS_LEFT     = 2'd0;
    localparam logic [POS_W-1:0]  POS_MIDDLE   = 2'd1;
    localparam logic [POS_W-1:0]  POS_UNLINKED = 2'd3;

    typedef struct packed {
        logic load;     // capture the item and start the store read
        logic fac1;     // scale product, first factor term
        logic fac2;     // second factor term
        logic mul_lo;   // product times low factor half
        logic mul_hi;   // product times high factor half, finish
        logic write;    // write back to the store
        logic emit;     // load the output register
    } mgp_cmd_t;

    typedef struct packed {
        logic in_range; // offered individual is inside the store
        logic last;     // held item closes the run
        logic out_free; // output register can take a result
    } mgp_sts_t;

endpackage
`default_nettype wire

### rtl/mgp_ctrl.sv
// Sequencer for one read-modify-write pass per item.
`default_nettype none
module mgp_ctrl
    import mgp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire mgp_sts_t sts,
    output mgp_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FAC1   = 3'd1;
    localparam logic [2:0] ST_FAC2   = 3'd2;
    localparam logic [2:0] ST_MUL_LO = 3'd3;
    localparam logic [2:0] ST_MUL_HI = 3'd4;
    localparam logic [2:0] ST_WRITE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load = 1'b1;
                    // drop items outside the store
                    if (sts.in_range) begin
                        state_next = ST_FAC1;
                    end
                end
            end
            ST_FAC1: begin
                cmd.fac1   = 1'b1;
                state_next = ST_FAC2;
            end
            ST_FAC2: begin
                cmd.fac2   = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                // for a last item, hold until the output register has room for a result
                if (!sts.last || sts.out_free) begin
                    cmd.write  = 1'b1;
                    cmd.emit   = sts.last;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

### rtl/mgp_datapath.sv
// Product store, shared multiplier and result register.
`default_nettype none
module mgp_datapath
    import mgp_pkg::*;
#(
    parameter int NUM_INDIVIDUALS = 1024
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mgp_cmd_t          cmd,
    output mgp_sts_t               sts,
    input  wire logic [IND_W-1:0]  in_individual,
    input  wire logic              in_first,
    input  wire logic              in_last,
    input  wire logic [GENO_W-1:0] in_geno_here,
    input  wire logic [GENO_W-1:0] in_geno_next,
    input  wire logic [POS_W-1:0]  in_position,
    input  wire logic [R_W-1:0]    in_recomb,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [IND_W-1:0]       out_individual,
    output logic [PROB_W-1:0]      out_probability
);

    localparam int ADDR_W = (NUM_INDIVIDUALS > 1) ? $clog2(NUM_INDIVIDUALS) : 1;

    logic [PROB_W-1:0] mem [NUM_INDIVIDUALS];

    logic [IND_W-1:0]  ind_reg;
    logic              first_reg;
    logic              last_reg;
    logic [GENO_W-1:0] gh_reg;
    logic [GENO_W-1:0] gn_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [R_W-1:0]    r_reg;
    logic [PROB_W-1:0] rd_data_reg;
    logic [PROB_W-1:0] p_reg;
    logic [FAC_W-1:0]  fac_reg;
    logic [PROB_W-1:0] acc_reg;
    logic [PROB_W-1:0] res_reg;
    logic              out_valid_reg;
    logic [IND_W-1:0]  out_ind_reg;
    logic [PROB_W-1:0] out_prob_reg;

    logic [ADDR_W-1:0]   in_addr;
    logic [ADDR_W-1:0]   addr;
    logic [Q_W-1:0]      r_ext;
    logic [Q_W-1:0]      q_val;
    logic [GENO_W-1:0]   diff;
    logic                het_het;
    logic                dbl;
    logic                use_trans;
    logic [PROB_W-1:0]   p_start;
    logic [PROB_W+2:0]   p_times7;
    logic [PROB_W:0]     p_175;
    logic [PROB_W-1:0]   p_sat;
    logic [PROB_W-1:0]   p_scaled;
    logic [MUL_AW-1:0]   mul_a;
    logic [MUL_BW-1:0]   mul_b;
    logic [MUL_PW-1:0]   mul_p;
    logic [MUL_PW:0]     hi_sum;

    assign in_addr      = ADDR_W'(in_individual);
    assign addr         = ADDR_W'(ind_reg);
    assign sts.in_range = ({7'd0, in_individual} < 17'(NUM_INDIVIDUALS));
    assign sts.last     = last_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    // transition factor selection
    assign r_ext   = {1'b0, r_reg};
    assign q_val   = Q_ONE - r_ext;
    assign diff    = (gh_reg > gn_reg) ? (gh_reg - gn_reg) : (gn_reg - gh_reg);
    assign het_het = (gh_reg == GENO_HET) && (gn_reg == GENO_HET);
    assign dbl     = (diff == 2'd1) && (gn_reg == GENO_HET);
    assign use_trans = (pos_reg == POS_LEFT) || (pos_reg == POS_MIDDLE);

    // 1.75 step with saturation, then marginal scaling at left and unlinked loci
    assign p_start  = first_reg ? PROB_ONE : rd_data_reg;
    assign p_times7 = {p_start, 3'b000} - {3'b000, p_start};
    assign p_175    = p_times7[PROB_W+2:2];
    assign p_sat    = p_175[PROB_W] ? {PROB_W{1'b1}} : p_175[PROB_W-1:0];

    always_comb begin
        p_scaled = p_sat;
        if ((pos_reg == POS_LEFT) || (pos_reg == POS_UNLINKED)) begin
            p_scaled = (gh_reg == GENO_HET) ? (p_sat >> 1) : (p_sat >> 2);
        end
    end

    always_comb begin
        mul_a = MUL_AW'(r_ext);
        mul_b = r_ext;
        if (cmd.fac1) begin
            if (diff == 2'd0) begin
                mul_a = MUL_AW'(q_val);
                mul_b = q_val;
            end else if (diff == 2'd1) begin
                mul_b = q_val;
            end
        end else if (cmd.mul_lo) begin
            mul_a = p_reg;
            mul_b = {1'b0, fac_reg[15:0]};
        end else if (cmd.mul_hi) begin
            mul_a = p_reg;
            mul_b = fac_reg[FAC_W-1:16];
        end
    end

    assign mul_p  = {{MUL_BW{1'b0}}, mul_a} * {{MUL_AW{1'b0}}, mul_b};
    assign hi_sum = {1'b0, mul_p} + (MUL_PW+1)'(acc_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ind_reg     <= in_individual;
            first_reg   <= in_first;
            last_reg    <= in_last;
            gh_reg      <= in_geno_here;
            gn_reg      <= in_geno_next;
            pos_reg     <= in_position;
            r_reg       <= in_recomb;
            rd_data_reg <= mem[in_addr];
        end
        if (cmd.fac1) begin
            p_reg   <= p_scaled;
            fac_reg <= dbl ? {mul_p[FAC_W-2:0], 1'b0} : mul_p[FAC_W-1:0];
        end
        if (cmd.fac2 && het_het) begin
            fac_reg <= fac_reg + mul_p[FAC_W-1:0];
        end
        if (cmd.mul_lo) begin
            acc_reg <= mul_p[PROB_W+15:16];
        end
        if (cmd.mul_hi) begin
            res_reg <= use_trans ? hi_sum[PROB_W+15:16] : p_reg;
        end
        if (cmd.write) begin
            mem[addr] <= res_reg;
        end
        if (cmd.emit) begin
            out_ind_reg  <= ind_reg;
            out_prob_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_individual  = out_ind_reg;
    assign out_probability = out_prob_reg;

endmodule
`default_nettype wire

### rtl/marker_genotype_probability_core.sv
// Top level of the marker genotype probability block.
//
//  channel | dir | handshake        | contents
//  --------+-----+------------------+-------------------------------------------
//  s_      | in  | s_tvalid/tready  | one locus step for one individual
//  m_      | out | m_tvalid/tready  | finished probability after the last locus
//
// Each kept item passes the accept step (store read), a scale and factor step,
// a second factor step, a low and a high multiply step on the shared 48x17
// multiplier, and a write-back step on the product store port.
// The write-back of a last-locus item waits while the output register is full;
// a new item is taken while an earlier result still sits in that register.
// aresetn clears the sequencer and the output valid; store contents stay
// undefined until each individual is started with a first-locus item.
// Items whose individual lies outside the store are transferred and dropped.
`default_nettype none
module marker_genotype_probability_core
    import mgp_pkg::*;
#(
    parameter int NUM_INDIVIDUALS = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [9:0] individual, [11:10] geno_here, [13:12] geno_next,
    // [29:14] recomb_frac, [31:30] zero
    input  wire logic [31:0] s_tdata,
    // [0] first_locus, [2:1] position_code
    input  wire logic [2:0]  s_tuser,
    input  wire logic        s_tlast,  // last_locus
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [9:0] individual_out, [57:10] probability, [63:58] zero
    output logic [63:0]      m_tdata
);

    mgp_cmd_t          cmd;
    mgp_sts_t          sts;
    logic [IND_W-1:0]  out_individual;
    logic [PROB_W-1:0] out_probability;

    mgp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // unpack the input transfer into its fields
    mgp_datapath #(
        .NUM_INDIVIDUALS (NUM_INDIVIDUALS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .in_individual   (s_tdata[9:0]),
        .in_first        (s_tuser[0]),
        .in_last         (s_tlast),
        .in_geno_here    (s_tdata[11:10]),
        .in_geno_next    (s_tdata[13:12]),
        .in_position     (s_tuser[2:1]),
        .in_recomb       (s_tdata[29:14]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_individual  (out_individual),
        .out_probability (out_probability)
    );

    assign m_tdata = {6'd0, out_probability, out_individual};

    // a kept item blocks the input until its write-back
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && sts.in_range) |=> !s_tready)
        else $error("input taken while an item is in flight");

    // a result is only loaded into a free output register
    a_emit_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result overwrote a pending output transfer");

    // output valid only rises from an emitted write-back
    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.emit && cmd.write))
        else $error("output valid without a finished item");

endmodule
`default_nettype wire
